@@ design/ffpa_pkg.sv @@
package ffpa_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned PID_W    = 8;
  localparam int unsigned REQ_W    = 11;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_INIT  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_SHIFT,
    S_PLACE,
    S_AGE,
    S_MERGE,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic init_step;
    logic scan_step;
    logic full;
    logic shift_start;
    logic shift_step;
    logic place;
    logic age_step;
    logic merge_start;
    logic merge_step;
    logic clear_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic   cnt_last;
    logic   init_last;
    logic   scan_hit;
    logic   scan_split;
    logic   table_full;
    logic   reject;
    logic   shift_last;
    logic   clear_last;
    cmd_t   command;
    cmd_t   in_command;
  } ctl_sts_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [PID_W-1:0]  process_id;
    logic [REQ_W-1:0]  request_size;
    logic [TICK_W-1:0] hold_ticks;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic [COUNT_W-1:0]  freed_count;
    logic [COUNT_W-1:0]  partition_count;
  } out_item_t;

endpackage

@@ design/ffpa_if.sv @@
interface ffpa_in_if;
  import ffpa_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ffpa_out_if;
  import ffpa_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/ffpa_ctrl.sv @@
module ffpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ffpa_pkg::ctl_sts_t  sts,
  output ffpa_pkg::ctl_cmd_t  cmd
);
  import ffpa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (sts.in_command)
            CMD_ALLOC: state_nxt = S_SCAN;
            CMD_TICK:  state_nxt = S_AGE;
            CMD_INIT:  state_nxt = S_INIT;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) begin
          state_nxt = (sts.command == CMD_INIT) ? S_DONE : S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.reject) begin
          state_nxt = S_DONE;
        end else if (sts.scan_hit) begin
          if (!sts.scan_split) begin
            cmd.place = 1'b1;
            state_nxt = S_DONE;
          end else if (sts.table_full) begin
            cmd.full  = 1'b1;
            state_nxt = S_DONE;
          end else begin
            cmd.shift_start = 1'b1;
            state_nxt       = S_SHIFT;
          end
        end else if (sts.cnt_last) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.shift_last) begin
          state_nxt = S_PLACE;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_DONE;
      end
      S_AGE: begin
        cmd.age_step = 1'b1;
        if (sts.cnt_last) begin
          cmd.merge_start = 1'b1;
          state_nxt       = S_MERGE;
        end
      end
      S_MERGE: begin
        cmd.merge_step = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ design/ffpa_datapath.sv @@
module ffpa_datapath #(
  parameter int unsigned MAX_MEMORY = 1024,
  parameter int unsigned MAX_PARTS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [10:0]         cfg_wdata,
  input  ffpa_pkg::in_item_t  in_item,
  input  ffpa_pkg::ctl_cmd_t  cmd,
  output ffpa_pkg::ctl_sts_t  sts,
  output ffpa_pkg::out_item_t out_item
);
  import ffpa_pkg::*;

  localparam int unsigned IDX_W  = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_PARTS + 1);
  localparam int unsigned SIZE_W = $clog2(MAX_MEMORY + 1);
  localparam int unsigned MS_W   = (SIZE_W > REQ_W) ? SIZE_W : REQ_W;
  localparam logic [CNT_W-1:0] PARTS_C = CNT_W'(MAX_PARTS);
  localparam logic [MS_W-1:0]  MAXM_C  = MS_W'(MAX_MEMORY);

  logic [SIZE_W-1:0] size_r  [MAX_PARTS];
  logic [PID_W-1:0]  owner_r [MAX_PARTS];
  logic [TICK_W-1:0] ticks_r [MAX_PARTS];

  logic [REQ_W-1:0]    mem_size_r;
  logic [CNT_W-1:0]    total_r;
  in_item_t            item_r;
  logic [CNT_W-1:0]    rd_r;
  logic [CNT_W-1:0]    wr_r;
  logic [COUNT_W-1:0]  freed_r;
  logic [STATUS_W-1:0] status_r;
  logic [SLOT_W-1:0]   slot_r;

  logic [IDX_W-1:0]  ri, wi, wm;
  logic [SIZE_W-1:0] cur_size;
  logic [PID_W-1:0]  cur_owner;
  logic [TICK_W-1:0] cur_ticks;
  logic [MS_W-1:0]   init_sz;
  logic [MS_W:0]     req_ext;
  logic [SIZE_W-1:0] remain;

  assign ri        = rd_r[IDX_W-1:0];
  assign wi        = wr_r[IDX_W-1:0];
  assign wm        = IDX_W'(wr_r - CNT_W'(1));
  assign cur_size  = size_r[ri];
  assign cur_owner = owner_r[ri];
  assign cur_ticks = ticks_r[ri];
  assign init_sz   = (MS_W'(mem_size_r) > MAXM_C) ? MAXM_C : MS_W'(mem_size_r);
  assign req_ext   = (MS_W + 1)'(item_r.request_size);
  assign remain    = SIZE_W'((MS_W + 1)'(cur_size) - req_ext);

  always_comb begin
    sts.command    = cmd_t'(item_r.command);
    sts.in_command = cmd_t'(in_item.command);
    sts.cnt_last   = (rd_r + CNT_W'(1) >= total_r) ||
                     (rd_r == PARTS_C - CNT_W'(1));
    sts.init_last  = (rd_r == PARTS_C - CNT_W'(1));
    sts.reject     = (item_r.request_size == '0) || (item_r.process_id == '0);
    sts.scan_hit   = (cur_owner == '0) && ((MS_W + 1)'(cur_size) >= req_ext);
    sts.scan_split = ((MS_W + 1)'(cur_size) != req_ext);
    sts.table_full = (total_r >= PARTS_C);
    sts.shift_last = (wr_r <= rd_r + CNT_W'(1));
    sts.clear_last = (wr_r >= PARTS_C - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_size_r <= REQ_W'(1024);
    end else if (cfg_we) begin
      mem_size_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r     <= '0;
      total_r  <= CNT_W'(1);
      item_r   <= '0;
    end else begin
      if (cmd.load) begin
        item_r   <= in_item;
        rd_r     <= '0;
        freed_r  <= '0;
        status_r <= (in_item.command == CMD_ALLOC) ? ST_NOFIT : ST_DONE;
        slot_r   <= '0;
      end
      if (cmd.init_step) begin
        size_r[ri]  <= (rd_r == '0) ? SIZE_W'(init_sz) : '0;
        owner_r[ri] <= '0;
        ticks_r[ri] <= '0;
        rd_r        <= sts.init_last ? '0 : rd_r + CNT_W'(1);
        if (sts.init_last) begin
          total_r <= CNT_W'(1);
        end
      end
      if (cmd.scan_step) begin
        rd_r <= rd_r + CNT_W'(1);
      end
      if (cmd.full) begin
        status_r <= ST_FULL;
      end
      if (cmd.shift_start) begin
        wr_r <= total_r;
      end
      if (cmd.shift_step) begin
        size_r[wi]  <= size_r[wm];
        owner_r[wi] <= owner_r[wm];
        ticks_r[wi] <= ticks_r[wm];
        wr_r        <= wr_r - CNT_W'(1);
      end
      if (cmd.place) begin
        owner_r[ri] <= item_r.process_id;
        ticks_r[ri] <= item_r.hold_ticks;
        status_r    <= ST_DONE;
        slot_r      <= SLOT_W'(rd_r);
        if (sts.scan_split) begin
          size_r[ri]                 <= SIZE_W'(item_r.request_size);
          size_r[IDX_W'(rd_r + 1)]   <= remain;
          owner_r[IDX_W'(rd_r + 1)]  <= '0;
          ticks_r[IDX_W'(rd_r + 1)]  <= '0;
          total_r                    <= total_r + CNT_W'(1);
        end
      end
      if (cmd.age_step) begin
        if (cur_ticks != '0) begin
          ticks_r[ri] <= cur_ticks - TICK_W'(1);
        end else if (cur_owner != '0) begin
          owner_r[ri] <= '0;
          freed_r     <= freed_r + COUNT_W'(1);
        end
        rd_r <= sts.cnt_last ? '0 : rd_r + CNT_W'(1);
      end
      if (cmd.merge_start) begin
        wr_r <= '0;
      end
      if (cmd.merge_step) begin
        if (wr_r != '0 && cur_owner == '0 && owner_r[wm] == '0) begin
          size_r[wm] <= size_r[wm] + cur_size;
        end else begin
          size_r[wi]  <= cur_size;
          owner_r[wi] <= cur_owner;
          ticks_r[wi] <= cur_ticks;
          wr_r        <= wr_r + CNT_W'(1);
        end
        rd_r <= rd_r + CNT_W'(1);
      end
      if (cmd.clear_step) begin
        if (wr_r < PARTS_C) begin
          size_r[wi]  <= '0;
          owner_r[wi] <= '0;
          ticks_r[wi] <= '0;
        end
        if (rd_r != '0) begin
          total_r <= wr_r;
          rd_r    <= '0;
        end
        wr_r <= (wr_r < PARTS_C) ? wr_r + CNT_W'(1) : wr_r;
      end
    end
  end

  assign out_item.status          = status_r;
  assign out_item.slot_index      = slot_r;
  assign out_item.freed_count     = freed_r;
  assign out_item.partition_count = COUNT_W'(total_r);

endmodule

@@ design/first_fit_partition_allocator.sv @@
// First-fit partition allocator. One item is taken at a time and its result is
// held until taken. An allocate walks the table one entry a cycle up to the
// first fit, then opens a slot by moving one entry a cycle. A tick ages one
// entry a cycle, merges one a cycle and clears the emptied tail. Init rewrites
// every entry, and the same sweep runs once after reset before the first item
// is taken. After the result is taken the block passes through idle before it
// takes the next item. A memory_size write takes effect at the next init.
module first_fit_partition_allocator #(
  parameter int unsigned MAX_MEMORY = 1024,
  parameter int unsigned MAX_PARTS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  ffpa_in_if.sink     in_ch,
  ffpa_out_if.source  out_ch
);
  import ffpa_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  ffpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffpa_datapath #(
    .MAX_MEMORY (MAX_MEMORY),
    .MAX_PARTS  (MAX_PARTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_ch.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_ch.data)
  );

endmodule
